[hdl/swsr_pkg.sv]
// Shared types and constants for the single-wire sensor reader.
package swsr_pkg;

  // Field and counter widths
  localparam int CNT_W      = 15;
  localparam int SHORT_W    = 8;
  localparam int BIT_IDX_W  = 3;
  localparam int BYTE_IDX_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Default frame length in bytes
  localparam int BYTES_PER_FRAME_DEF = 5;

  // Register values after reset
  localparam logic [CNT_W-1:0]   START_LOW_RST     = 15'd18000;
  localparam logic [SHORT_W-1:0] RELEASE_HIGH_RST  = 8'd20;
  localparam logic [SHORT_W-1:0] RESPONSE_CHECK_RST = 8'd40;
  localparam logic [SHORT_W-1:0] RESPONSE_HOLD_RST = 8'd80;
  localparam logic [SHORT_W-1:0] BIT_SAMPLE_RST    = 8'd40;

  // Top bit position within a byte
  localparam logic [BIT_IDX_W-1:0] BIT_IDX_LAST = 3'd7;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_LOW      = 3'd0,
    CFG_RELEASE_HIGH   = 3'd1,
    CFG_RESPONSE_CHECK = 3'd2,
    CFG_RESPONSE_HOLD  = 3'd3,
    CFG_BIT_SAMPLE     = 3'd4
  } cfg_idx_t;

  // Response status codes
  typedef enum logic [1:0] {
    RESP_NONE = 2'd0,
    RESP_OK   = 2'd1,
    RESP_BAD  = 2'd2
  } resp_t;

  // Protocol phases
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_LOW  = 4'd1,
    PH_START_HIGH = 4'd2,
    PH_CHECK1     = 4'd3,
    PH_CHECK2     = 4'd4,
    PH_WAIT_LOW   = 4'd5,
    PH_RISE       = 4'd6,
    PH_SAMPLE     = 4'd7,
    PH_FALL       = 4'd8,
    PH_FALL_LAST  = 4'd9
  } phase_t;

  // Timing registers as seen by the protocol engine
  typedef struct packed {
    logic [CNT_W-1:0]   start_low_us;
    logic [SHORT_W-1:0] release_high_us;
    logic [SHORT_W-1:0] response_check_us;
    logic [SHORT_W-1:0] response_hold_us;
    logic [SHORT_W-1:0] bit_sample_us;
  } cfg_t;

  // One input word: one microsecond tick
  typedef struct packed {
    logic start_req;
    logic pin_level;
  } in_item_t;

  // One result word
  typedef struct packed {
    logic         drive_enable;
    logic         drive_level;
    logic         response_valid;
    logic [1:0]   response_status;
    logic         byte_valid;
    logic [7:0]   byte_data;
    logic         last_byte;
    logic         busy_res;
  } out_item_t;

endpackage

[hdl/single_wire_sensor_reader.sv]
// An accepted word is held in the input register until the output register takes its result.
// Throughput: one word per cycle; the input register, the protocol step and the output
//   register form a single stage that advances whenever the output register is free.
// Reset (rst_n low, synchronous): engine idle, counters and indexes cleared, both
//   registers empty, timing registers back to 18000/20/40/80/40 us.
// Top level of the single-wire sensor reader.
module single_wire_sensor_reader #(
  parameter int BYTES_PER_FRAME = swsr_pkg::BYTES_PER_FRAME_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  swsr_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output swsr_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [swsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swsr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import swsr_pkg::*;

  cfg_t      cfg;
  out_item_t result;

  logic      in_full_r, in_full_nxt;
  in_item_t  in_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      fire;

  swsr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  swsr_fsm #(
    .BYTES_PER_FRAME (BYTES_PER_FRAME)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (fire),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // Process the held word when the output register can take its result
  assign fire     = in_full_r && (!out_valid_r || out_ready);
  assign in_ready = !in_full_r || fire;

  always_comb begin
    in_full_nxt = in_full_r;
    if (in_valid && in_ready) begin
      in_full_nxt = 1'b1;
    end else if (fire) begin
      in_full_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A held word that is not processed stays in place
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_full_r && !fire |=> in_full_r && $stable(in_item_r))
    else $error("input word lost while waiting");

  // Response report and byte report never share a word
  a_one_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.response_valid && out_data_r.byte_valid))
    else $error("response and byte reported together");

  // Last-byte flag only comes with a byte
  a_last_with_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last_byte |-> out_data_r.byte_valid)
    else $error("last_byte without byte_valid");

  // A nonzero status only comes with a response report
  a_status_with_resp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.response_status != RESP_NONE) |-> out_data_r.response_valid)
    else $error("status without response_valid");

endmodule

[hdl/swsr_cfg.sv]
// Timing configuration registers with a plain write port.
module swsr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [swsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swsr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output swsr_pkg::cfg_t                    cfg
);
  import swsr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_START_LOW:      cfg_nxt.start_low_us      = cfg_wdata[CNT_W-1:0];
        CFG_RELEASE_HIGH:   cfg_nxt.release_high_us   = cfg_wdata[SHORT_W-1:0];
        CFG_RESPONSE_CHECK: cfg_nxt.response_check_us = cfg_wdata[SHORT_W-1:0];
        CFG_RESPONSE_HOLD:  cfg_nxt.response_hold_us  = cfg_wdata[SHORT_W-1:0];
        CFG_BIT_SAMPLE:     cfg_nxt.bit_sample_us     = cfg_wdata[SHORT_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_us      <= START_LOW_RST;
      cfg_r.release_high_us   <= RELEASE_HIGH_RST;
      cfg_r.response_check_us <= RESPONSE_CHECK_RST;
      cfg_r.response_hold_us  <= RESPONSE_HOLD_RST;
      cfg_r.bit_sample_us     <= BIT_SAMPLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/swsr_fsm.sv]
// Protocol engine: state registers and the per-tick next-state and result logic.
module swsr_fsm #(
  parameter int BYTES_PER_FRAME = swsr_pkg::BYTES_PER_FRAME_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  swsr_pkg::in_item_t   item,
  input  swsr_pkg::cfg_t       cfg,
  output swsr_pkg::out_item_t  result
);
  import swsr_pkg::*;

  localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = BYTE_IDX_W'(BYTES_PER_FRAME - 1);

  phase_t                phase_r,    phase_nxt;
  logic [CNT_W-1:0]      cnt_r,      cnt_nxt;
  logic [7:0]            shift_r,    shift_nxt;
  logic [BIT_IDX_W-1:0]  bit_idx_r,  bit_idx_nxt;
  logic [BYTE_IDX_W-1:0] byte_idx_r, byte_idx_nxt;
  logic [1:0]            resp_ok_r,  resp_ok_nxt;
  out_item_t             res;

  always_comb begin
    logic final_byte;
    logic start;
    logic pin;
    start        = item.start_req;
    pin          = item.pin_level;
    final_byte   = 1'b0;
    res          = '0;
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    shift_nxt    = shift_r;
    bit_idx_nxt  = bit_idx_r;
    byte_idx_nxt = byte_idx_r;
    resp_ok_nxt  = resp_ok_r;

    // Treat an unknown phase code as idle
    if (!(phase_r inside {PH_IDLE, PH_START_LOW, PH_START_HIGH, PH_CHECK1, PH_CHECK2,
                          PH_WAIT_LOW, PH_RISE, PH_SAMPLE, PH_FALL, PH_FALL_LAST})) begin
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
    end

    // Start sequence: zero-length phases fall through within the same tick
    if (phase_r == PH_IDLE && start) begin
      res.busy_res = 1'b1;
      shift_nxt    = '0;
      bit_idx_nxt  = '0;
      byte_idx_nxt = '0;
      resp_ok_nxt  = RESP_NONE;
      phase_nxt    = PH_START_LOW;
      cnt_nxt      = '0;
    end

    if (phase_nxt == PH_START_LOW) begin
      res.busy_res = 1'b1;
      if (cnt_nxt >= cfg.start_low_us) begin
        phase_nxt = PH_START_HIGH;
        cnt_nxt   = '0;
      end else begin
        res.drive_enable = 1'b1;
        cnt_nxt          = cnt_nxt + 1'b1;
      end
    end

    if (phase_nxt == PH_START_HIGH) begin
      res.busy_res = 1'b1;
      if (cnt_nxt >= CNT_W'(cfg.release_high_us)) begin
        phase_nxt = PH_CHECK1;
        cnt_nxt   = '0;
      end else begin
        res.drive_enable = 1'b1;
        res.drive_level  = 1'b1;
        cnt_nxt          = cnt_nxt + 1'b1;
      end
    end

    if (phase_nxt == PH_CHECK1) begin
      res.busy_res = 1'b1;
      if (cnt_nxt >= CNT_W'(cfg.response_check_us)) begin
        cnt_nxt = '0;
        if (pin) begin
          resp_ok_nxt         = RESP_NONE;
          res.response_valid  = 1'b1;
          res.response_status = RESP_NONE;
          phase_nxt           = PH_WAIT_LOW;
        end else begin
          phase_nxt = PH_CHECK2;
        end
      end else begin
        cnt_nxt = cnt_nxt + 1'b1;
      end
    end

    if (phase_nxt == PH_CHECK2) begin
      res.busy_res = 1'b1;
      if (cnt_nxt >= CNT_W'(cfg.response_hold_us)) begin
        cnt_nxt            = '0;
        res.response_valid = 1'b1;
        if (pin) begin
          resp_ok_nxt         = RESP_OK;
          res.response_status = RESP_OK;
          phase_nxt           = PH_WAIT_LOW;
        end else begin
          resp_ok_nxt         = RESP_BAD;
          res.response_status = RESP_BAD;
          phase_nxt           = PH_IDLE;
        end
      end else begin
        cnt_nxt = cnt_nxt + 1'b1;
      end
    end

    // Data phases act only on the phase held at the start of the tick
    case (phase_r)
      PH_WAIT_LOW: begin
        res.busy_res = 1'b1;
        if (!pin) begin
          phase_nxt = (resp_ok_r == RESP_OK) ? PH_RISE : PH_IDLE;
          cnt_nxt   = '0;
        end
      end
      PH_RISE: begin
        res.busy_res = 1'b1;
        if (pin) begin
          phase_nxt = PH_SAMPLE;
          cnt_nxt   = '0;
        end
      end
      PH_SAMPLE: begin
        res.busy_res = 1'b1;
        if (cnt_r >= CNT_W'(cfg.bit_sample_us)) begin
          final_byte                       = (byte_idx_r == LAST_BYTE_IDX);
          shift_nxt[BIT_IDX_LAST - bit_idx_r] = pin;
          cnt_nxt                          = '0;
          if (bit_idx_r == BIT_IDX_LAST) begin
            res.byte_valid = 1'b1;
            res.byte_data  = shift_nxt;
            res.last_byte  = final_byte;
            bit_idx_nxt    = '0;
            byte_idx_nxt   = final_byte ? '0 : byte_idx_r + 1'b1;
          end else begin
            bit_idx_nxt = bit_idx_r + 1'b1;
          end
          if (bit_idx_r == BIT_IDX_LAST && final_byte) begin
            phase_nxt = pin ? PH_FALL_LAST : PH_IDLE;
          end else begin
            phase_nxt = pin ? PH_FALL : PH_RISE;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      PH_FALL: begin
        res.busy_res = 1'b1;
        if (!pin) begin
          phase_nxt = PH_RISE;
          cnt_nxt   = '0;
        end
      end
      PH_FALL_LAST: begin
        res.busy_res = 1'b1;
        if (!pin) begin
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
        end
      end
      default: ;
    endcase
  end

  // Advance the state once per processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cnt_r      <= '0;
      shift_r    <= '0;
      bit_idx_r  <= '0;
      byte_idx_r <= '0;
      resp_ok_r  <= RESP_NONE;
    end else if (step) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      shift_r    <= shift_nxt;
      bit_idx_r  <= bit_idx_nxt;
      byte_idx_r <= byte_idx_nxt;
      resp_ok_r  <= resp_ok_nxt;
    end
  end

  assign result = res;

endmodule

[dv/tb_single_wire_sensor_reader.sv]
// Testbench for the single-wire sensor reader: sensor waveforms in, per-tick result words checked.
module tb_single_wire_sensor_reader;
  import swsr_pkg::*;

  localparam int FRAME_BYTES = BYTES_PER_FRAME_DEF;
  localparam int CLK_HALF    = 6;
  localparam int RUN_LIMIT   = 12 * 1000000;
  localparam int IDLE_PCT    = 20;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  single_wire_sensor_reader #(.BYTES_PER_FRAME(FRAME_BYTES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the link engine
  cfg_t                  timing;
  phase_t                ph;
  logic [CNT_W-1:0]      tcnt;
  logic [7:0]            shreg;
  logic [BIT_IDX_W-1:0]  bidx;
  logic [BYTE_IDX_W-1:0] byidx;
  resp_t                 rok;

  out_item_t  expected_words[$];
  logic [7:0] frame_bytes [FRAME_BYTES];
  bit         no_idle = 1'b0;
  int         errors = 0;
  int         words_checked = 0;
  int         busy_words = 0;
  int         bytes_seen = 0;
  int         settings_used = 1;
  int         resp_seen [3] = '{0, 0, 0};

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop
  initial begin
    #(RUN_LIMIT);
    $display("tb_single_wire_sensor_reader: errors");
    $finish;
  end

  function automatic void enter_phase(phase_t p);
    ph   = p;
    tcnt = '0;
  endfunction

  // Count one tick of a timed phase; true once the length has passed
  function automatic bit elapsed(logic [CNT_W-1:0] len);
    if (tcnt >= len) return 1'b1;
    tcnt = tcnt + 1'b1;
    return 1'b0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_START_LOW:      timing.start_low_us      = val;
      CFG_RELEASE_HIGH:   timing.release_high_us   = val[SHORT_W-1:0];
      CFG_RESPONSE_CHECK: timing.response_check_us = val[SHORT_W-1:0];
      CFG_RESPONSE_HOLD:  timing.response_hold_us  = val[SHORT_W-1:0];
      CFG_BIT_SAMPLE:     timing.bit_sample_us     = val[SHORT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void reset_line_model();
    timing.start_low_us      = START_LOW_RST;
    timing.release_high_us   = RELEASE_HIGH_RST;
    timing.response_check_us = RESPONSE_CHECK_RST;
    timing.response_hold_us  = RESPONSE_HOLD_RST;
    timing.bit_sample_us     = BIT_SAMPLE_RST;
    ph    = PH_IDLE;
    tcnt  = '0;
    shreg = '0;
    bidx  = '0;
    byidx = '0;
    rok   = RESP_NONE;
  endfunction

  // Advance the shadow engine by one microsecond tick and return its result word
  function automatic out_item_t step_line(in_item_t w);
    out_item_t            r;
    bit                   again;
    bit                   final_b;
    bit                   end_f;
    logic [BIT_IDX_W-1:0] sh;
    r = '0;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (ph)
        PH_IDLE: begin
          if (w.start_req) begin
            r.busy_res = 1'b1;
            shreg = '0;
            bidx  = '0;
            byidx = '0;
            rok   = RESP_NONE;
            enter_phase(PH_START_LOW);
            again = 1'b1;
          end
        end
        PH_START_LOW: begin
          r.busy_res = 1'b1;
          if (elapsed(timing.start_low_us)) begin
            enter_phase(PH_START_HIGH);
            again = 1'b1;
          end else begin
            r.drive_enable = 1'b1;
            r.drive_level  = 1'b0;
          end
        end
        PH_START_HIGH: begin
          r.busy_res = 1'b1;
          if (elapsed(CNT_W'(timing.release_high_us))) begin
            enter_phase(PH_CHECK1);
            again = 1'b1;
          end else begin
            r.drive_enable = 1'b1;
            r.drive_level  = 1'b1;
          end
        end
        PH_CHECK1: begin
          r.busy_res = 1'b1;
          if (elapsed(CNT_W'(timing.response_check_us))) begin
            if (w.pin_level) begin
              rok = RESP_NONE;
              r.response_valid  = 1'b1;
              r.response_status = RESP_NONE;
              enter_phase(PH_WAIT_LOW);
            end else begin
              enter_phase(PH_CHECK2);
              again = 1'b1;
            end
          end
        end
        PH_CHECK2: begin
          r.busy_res = 1'b1;
          if (elapsed(CNT_W'(timing.response_hold_us))) begin
            r.response_valid = 1'b1;
            if (w.pin_level) begin
              rok = RESP_OK;
              r.response_status = RESP_OK;
              enter_phase(PH_WAIT_LOW);
            end else begin
              rok = RESP_BAD;
              r.response_status = RESP_BAD;
              enter_phase(PH_IDLE);
            end
          end
        end
        PH_WAIT_LOW: begin
          r.busy_res = 1'b1;
          if (!w.pin_level) enter_phase(rok == RESP_OK ? PH_RISE : PH_IDLE);
        end
        PH_RISE: begin
          r.busy_res = 1'b1;
          if (w.pin_level) enter_phase(PH_SAMPLE);
        end
        PH_SAMPLE: begin
          r.busy_res = 1'b1;
          if (elapsed(CNT_W'(timing.bit_sample_us))) begin
            sh = BIT_IDX_LAST - bidx;
            final_b = (byidx == BYTE_IDX_W'(FRAME_BYTES - 1));
            end_f = 1'b0;
            shreg[sh] = w.pin_level;
            if (bidx == BIT_IDX_LAST) begin
              r.byte_valid = 1'b1;
              r.byte_data  = shreg;
              r.last_byte  = final_b;
              bidx = '0;
              if (final_b) begin
                end_f = 1'b1;
                byidx = '0;
              end else begin
                byidx = byidx + 1'b1;
              end
            end else begin
              bidx = bidx + 1'b1;
            end
            if (end_f) enter_phase(w.pin_level ? PH_FALL_LAST : PH_IDLE);
            else       enter_phase(w.pin_level ? PH_FALL : PH_RISE);
          end
        end
        PH_FALL: begin
          r.busy_res = 1'b1;
          if (!w.pin_level) enter_phase(PH_RISE);
        end
        PH_FALL_LAST: begin
          r.busy_res = 1'b1;
          if (!w.pin_level) enter_phase(PH_IDLE);
        end
        default: enter_phase(PH_IDLE);
      endcase
    end
    return r;
  endfunction

  // Send one tick word; predict its result once it is accepted
  task automatic send_tick(input logic start, input logic pin);
    in_item_t  w;
    out_item_t r;
    w.start_req = start;
    w.pin_level = pin;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    r = step_line(w);
    if (r.busy_res) busy_words++;
    expected_words.push_back(r);
  endtask

  // Hold the input and wait for every outstanding result word
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  // Load all timing registers; the release and hold registers get junk in the unused upper bits
  task automatic set_timing(input int lo_us, input int hi_us, input int chk_us,
                            input int hold_us, input int smp_us);
    logic [CFG_DATA_W-1:0] junk;
    wait_drained();
    junk = CFG_DATA_W'($urandom) & ~CFG_DATA_W'(8'hFF);
    write_reg(CFG_START_LOW, CFG_DATA_W'(lo_us));
    write_reg(CFG_RELEASE_HIGH, junk | CFG_DATA_W'(hi_us));
    write_reg(CFG_RESPONSE_CHECK, CFG_DATA_W'(chk_us));
    write_reg(CFG_RESPONSE_HOLD, junk | CFG_DATA_W'(hold_us));
    write_reg(CFG_BIT_SAMPLE, CFG_DATA_W'(smp_us));
    if ($urandom_range(0, 1))
      write_reg(CFG_IDX_W'(CFG_BIT_SAMPLE) + CFG_IDX_W'($urandom_range(1, 3)),
                CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Toggle the line until the engine is idle again
  task automatic finish_frame();
    logic tog;
    tog = 1'b0;
    while (ph != PH_IDLE) begin
      send_tick(1'b0, tog);
      tog = ~tog;
    end
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic push_level(ref bit q[$], input bit lvl, input int n);
    repeat (n) q.push_back(lvl);
  endtask

  // Build a sensor waveform for one frame and play it from the start tick on
  task automatic play_frame(input resp_t kind);
    bit q[$];
    int host, c, h, s, d1, d2, d3, hi, lo;
    logic b;
    host = int'(timing.start_low_us) + int'(timing.release_high_us);
    c = int'(timing.response_check_us);
    h = int'(timing.response_hold_us);
    s = int'(timing.bit_sample_us);
    if (kind == RESP_OK && h == 0) kind = RESP_BAD;
    repeat (host) q.push_back(1'($urandom_range(0, 1)));
    case (kind)
      RESP_NONE: begin
        push_level(q, 1'b1, c + 1 + $urandom_range(0, 3));
        push_level(q, 1'b0, $urandom_range(1, 3));
        push_level(q, 1'b1, $urandom_range(1, 3));
      end
      RESP_BAD: begin
        d1 = $urandom_range(0, c);
        push_level(q, 1'b1, d1);
        push_level(q, 1'b0, c + h - d1 + 1 + $urandom_range(0, 3));
        push_level(q, 1'b1, 2);
      end
      default: begin
        d1 = $urandom_range(0, c);
        d2 = $urandom_range(c - d1 + 1, c + h - d1);
        d3 = c + h - d1 - d2 + 1 + $urandom_range(0, 3);
        push_level(q, 1'b1, d1);
        push_level(q, 1'b0, d2);
        push_level(q, 1'b1, d3);
        push_level(q, 1'b0, $urandom_range(1, 3));
        // One pulse per bit: long high for a one, short high for a zero
        for (int i = 0; i < FRAME_BYTES; i++) begin
          for (int k = 7; k >= 0; k--) begin
            b = frame_bytes[i][k];
            if (b) begin
              hi = s + 2 + $urandom_range(0, 2);
              lo = $urandom_range(1, 3);
            end else begin
              hi = $urandom_range(1, s + 1);
              lo = ((s + 2 - hi) > 1 ? (s + 2 - hi) : 1) + $urandom_range(0, 2);
            end
            push_level(q, 1'b1, hi);
            push_level(q, 1'b0, lo);
          end
        end
        push_level(q, 1'b1, 2);
      end
    endcase
    foreach (q[i])
      send_tick(i == 0 ? 1'b1 : (ph == PH_IDLE ? 1'b0 : 1'($urandom_range(0, 1))), q[i]);
    finish_frame();
  endtask

  // Random line and start activity after a start request
  task automatic play_noise(input int n);
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (n) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    finish_frame();
  endtask

  task automatic fill_bytes(input logic [7:0] first, input logic [7:0] rest);
    foreach (frame_bytes[i]) frame_bytes[i] = (i == 0) ? first : rest;
  endtask

  task automatic fill_random_bytes();
    foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom);
  endtask

  // Timing that reset leaves behind: long low phase, then release, check and hold
  task automatic test_reset_timing();
    idle_ticks(4);
    // Start and watch the line held low at the reset length
    send_tick(1'b1, 1'b1);
    repeat (15) send_tick(1'b0, 1'b1);
    // Cut the low phase short; the other reset lengths stay in force
    wait_drained();
    write_reg(CFG_START_LOW, CFG_DATA_W'(4));
    cfg_we <= 1'b0;
    @(posedge clk);
    // High line at the first check: no response
    while (ph != PH_IDLE) send_tick(1'b0, ph != PH_WAIT_LOW);
    idle_ticks(2);
    // Low line through both checks: bad response
    send_tick(1'b1, 1'b0);
    while (ph != PH_IDLE) send_tick(1'b0, 1'b0);
  endtask

  // Every response outcome at short timing
  task automatic test_response_kinds();
    set_timing(3, 2, 3, 4, 2);
    idle_ticks(3);
    play_frame(RESP_NONE);
    idle_ticks(2);
    play_frame(RESP_BAD);
    fill_bytes(8'h80, 8'h01);
    play_frame(RESP_OK);
  endtask

  // Zero lengths skip their phase in the same tick
  task automatic test_zero_lengths();
    no_idle = 1'b1;
    set_timing(0, 0, 0, 1, 0);
    fill_bytes(8'h55, 8'hAA);
    play_frame(RESP_OK);
    play_frame(RESP_NONE);
    play_frame(RESP_BAD);
    set_timing(0, 0, 0, 0, 0);
    play_frame(RESP_NONE);
    play_frame(RESP_BAD);
    no_idle = 1'b0;
  endtask

  // Longest check length an 8-bit register allows
  task automatic test_max_lengths();
    set_timing(1, 1, 255, 1, 1);
    play_frame(RESP_NONE);
  endtask

  task automatic test_noise();
    set_timing(2, 1, 2, 2, 1);
    play_noise(30);
    play_noise(8);
  endtask

  // Mostly well-formed frames with random data, some short outcomes and noise
  task automatic test_random_frames();
    int base, nfr, pick;
    base = busy_words;
    nfr = 0;
    while (busy_words - base < 150) begin
      if (nfr % 3 == 0)
        set_timing($urandom_range(0, 6), $urandom_range(0, 3), $urandom_range(0, 4),
                   $urandom_range(0, 4), $urandom_range(0, 3));
      no_idle = (nfr >= 3 && nfr < 6);
      pick = $urandom_range(0, 99);
      idle_ticks($urandom_range(0, 3));
      if (pick < 75) begin
        fill_random_bytes();
        play_frame(RESP_OK);
      end else if (pick < 85) begin
        play_frame(RESP_NONE);
      end else if (pick < 93) begin
        play_frame(RESP_BAD);
      end else begin
        play_noise($urandom_range(5, 40));
      end
      nfr++;
    end
    no_idle = 1'b0;
  endtask

  // Result side stalls
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare each result word against the oldest prediction
  always @(posedge clk) begin : check_words
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = expected_words.pop_front();
        check_field("drive_enable", 8'(want.drive_enable), 8'(out_data.drive_enable));
        check_field("drive_level", 8'(want.drive_level), 8'(out_data.drive_level));
        check_field("response_valid", 8'(want.response_valid), 8'(out_data.response_valid));
        check_field("response_status", 8'(want.response_status),
                    8'(out_data.response_status));
        check_field("byte_valid", 8'(want.byte_valid), 8'(out_data.byte_valid));
        check_field("byte_data", want.byte_data, out_data.byte_data);
        check_field("last_byte", 8'(want.last_byte), 8'(out_data.last_byte));
        check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
        words_checked++;
        if (want.response_valid) resp_seen[want.response_status]++;
        if (want.byte_valid) bytes_seen++;
      end
    end
  end

  initial begin
    reset_line_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_timing();
    test_response_kinds();
    test_zero_lengths();
    test_max_lengths();
    test_noise();
    test_random_frames();
    wait_drained();
    repeat (5) @(posedge clk);
    $display("checked %0d tick words over %0d timing settings, %0d of them busy",
             words_checked, settings_used, busy_words);
    $display("responses none/ok/bad %0d/%0d/%0d, data bytes %0d",
             resp_seen[0], resp_seen[1], resp_seen[2], bytes_seen);
    if (errors == 0) begin
      $display("tb_single_wire_sensor_reader: clean");
    end else begin
      $display("tb_single_wire_sensor_reader: errors");
    end
    $finish;
  end

endmodule

[single_wire_sensor_reader.f]
hdl/swsr_pkg.sv
hdl/swsr_cfg.sv
hdl/swsr_fsm.sv
hdl/single_wire_sensor_reader.sv
dv/tb_single_wire_sensor_reader.sv
